@@ rtl/ncbp_pkg.sv @@
package ncbp_pkg;

  localparam int unsigned MAX_ENTRIES_DEF   = 1024;
  localparam int unsigned MAX_SHORTLIST_DEF = 32;
  localparam int unsigned SHORTLIST_RESET   = 20;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned USE_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned PSZ_W  = 11;
  localparam int unsigned KSZ_W  = 6;
  localparam int unsigned DIST_W = 26;

  localparam logic [USE_W-1:0] USE_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_MATCH = 2'd0,
    ST_LOAD  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    REG_PSIZE = 1'b0,
    REG_KSIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_PICKW,
    S_UPD,
    S_OUT
  } fsm_t;

  // Squared distance between an 8.4 mean and a byte colour widened to 8.4
  function automatic logic [DIST_W-1:0] sq_dist(input logic [3*COL_W-1:0] c,
                                                input logic [PIX_W-1:0] p0,
                                                input logic [PIX_W-1:0] p1,
                                                input logic [PIX_W-1:0] p2);
    logic [COL_W-1:0] q [3];
    logic [COL_W-1:0] a;
    logic [COL_W-1:0] d;
    logic [DIST_W-1:0] s;
    q[0] = {p0, 4'h0};
    q[1] = {p1, 4'h0};
    q[2] = {p2, 4'h0};
    s = '0;
    for (int i = 0; i < 3; i++) begin
      a = c[i*COL_W +: COL_W];
      d = (a > q[i]) ? a - q[i] : q[i] - a;
      s = s + DIST_W'(d) * DIST_W'(d);
    end
    return s;
  endfunction

endpackage

@@ rtl/ncbp_if.sv @@
interface ncbp_in_if;
  import ncbp_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] entry_index;
  logic [COL_W-1:0] mean_c0;
  logic [COL_W-1:0] mean_c1;
  logic [COL_W-1:0] mean_c2;
  logic [PIX_W-1:0] pixel_c0;
  logic [PIX_W-1:0] pixel_c1;
  logic [PIX_W-1:0] pixel_c2;
  modport source (output valid, mode, entry_index, mean_c0, mean_c1, mean_c2,
                  pixel_c0, pixel_c1, pixel_c2, input ready);
  modport sink (input valid, mode, entry_index, mean_c0, mean_c1, mean_c2,
                pixel_c0, pixel_c1, pixel_c2, output ready);
endinterface

interface ncbp_out_if;
  import ncbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  chosen_index;
  logic [STAT_W-1:0] status;
  logic [USE_W-1:0]  chosen_uses;
  modport source (output valid, chosen_index, status, chosen_uses, input ready);
  modport sink (input valid, chosen_index, status, chosen_uses, output ready);
endinterface

@@ rtl/ncbp_ram.sv @@
module ncbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/ncbp_shortlist.sv @@
// Sorted list of the nearest entries, one insertion per cycle
module ncbp_shortlist
  import ncbp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES   = MAX_ENTRIES_DEF,
  parameter int unsigned MAX_SHORTLIST = MAX_SHORTLIST_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic                              ins,
  input  logic [DIST_W-1:0]                 cand_dist,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    idx,
  input  logic [$clog2(MAX_SHORTLIST+1)-1:0] k,
  input  logic [$clog2(MAX_SHORTLIST+1)-1:0] rsel,
  output logic [$clog2(MAX_ENTRIES)-1:0]    ridx,
  output logic [$clog2(MAX_SHORTLIST+1)-1:0] cnt
);
  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_SHORTLIST + 1);
  localparam int unsigned SW = (MAX_SHORTLIST > 1) ? $clog2(MAX_SHORTLIST) : 1;

  logic [DIST_W-1:0] sd [MAX_SHORTLIST];
  logic [AW-1:0]     si [MAX_SHORTLIST];
  logic [MAX_SHORTLIST-1:0] gt;
  logic full;
  logic [SW-1:0] k_last;

  assign full   = (cnt == k);
  assign k_last = SW'(k - CW'(1));

  // A slot holds a larger distance than the new one (ties keep earlier index)
  always_comb begin
    for (int j = 0; j < MAX_SHORTLIST; j++) begin
      gt[j] = (CW'(j) < cnt) && (sd[j] > cand_dist);
    end
  end

  // Shift larger entries down one slot and drop the new one in place
  always_ff @(posedge clk) begin
    if (ins && !(full && !gt[k_last])) begin
      for (int j = 0; j < MAX_SHORTLIST; j++) begin
        if (CW'(j) < k) begin
          if (gt[j]) begin
            if (j == 0 || !gt[(j == 0) ? 0 : j-1]) begin
              sd[j] <= cand_dist;
              si[j] <= idx;
            end else begin
              sd[j] <= sd[(j == 0) ? 0 : j-1];
              si[j] <= si[(j == 0) ? 0 : j-1];
            end
          end else if (CW'(j) == cnt) begin
            if (j == 0 || !gt[(j == 0) ? 0 : j-1]) begin
              sd[j] <= cand_dist;
              si[j] <= idx;
            end else begin
              sd[j] <= sd[(j == 0) ? 0 : j-1];
              si[j] <= si[(j == 0) ? 0 : j-1];
            end
          end
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= '0;
    end else if (ins && !full) begin
      cnt <= cnt + CW'(1);
    end
  end

  assign ridx = si[rsel[SW-1:0]];

  a_cnt_in_k: assert property (@(posedge clk) disable iff (rst)
    ins |-> cnt <= k)
    else $error("shortlist count above shortlist size");
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SHORTLIST))
    else $error("shortlist count above capacity");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clear |=> cnt == '0)
    else $error("shortlist not emptied by clear");
endmodule

@@ rtl/nearest_color_balanced_pick_top.sv @@
// Channel | Dir | Fields
// in      | in  | mode, entry_index, mean_c0..c2, pixel_c0..c2
// out     | out | chosen_index, status, chosen_uses
// apb     | in  | palette_size @0x0, shortlist_size @0x4
// A load or an empty-palette query is handled in the scan state alone. A query
// scans every entry (one color read per entry, n = palette_size capped at
// MAX_ENTRIES), then passes the drain state, a pick and a pick-wait state per
// shortlisted entry and the update state; the result then waits in the output
// register, and the block returns to idle after its transfer.
// rst is synchronous; in.ready is low while an item is in work or waits.
module nearest_color_balanced_pick_top
  import ncbp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES   = MAX_ENTRIES_DEF,
  parameter int unsigned MAX_SHORTLIST = MAX_SHORTLIST_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ncbp_in_if.sink     in,
  ncbp_out_if.source  out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_SHORTLIST + 1);
  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);

  fsm_t state, state_next;
  logic [PSZ_W-1:0] palette_size;
  logic [KSZ_W-1:0] shortlist_size;
  logic [NW-1:0] n_eff;
  logic [CW-1:0] k_eff;

  // Register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size   <= '0;
      shortlist_size <= KSZ_W'(SHORTLIST_RESET);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PSIZE) palette_size <= pwdata[PSZ_W-1:0];
      else shortlist_size <= pwdata[KSZ_W-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PSIZE) prdata[PSZ_W-1:0] = palette_size;
    else prdata[KSZ_W-1:0] = shortlist_size;
  end

  always_comb begin
    if (32'(palette_size) > MAX_ENTRIES) n_eff = NW'(MAX_ENTRIES);
    else n_eff = NW'(palette_size);
    if (shortlist_size == '0) k_eff = CW'(1);
    else if (32'(shortlist_size) > MAX_SHORTLIST) k_eff = CW'(MAX_SHORTLIST);
    else k_eff = CW'(shortlist_size);
  end

  // Captured item
  logic             q_mode;
  logic [IDX_W-1:0] q_idx;
  logic [3*COL_W-1:0] q_col;
  logic [PIX_W-1:0] p0, p1, p2;
  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      q_mode <= in.mode;
      q_idx  <= in.entry_index;
      q_col  <= {in.mean_c2, in.mean_c1, in.mean_c0};
      p0 <= in.pixel_c0;
      p1 <= in.pixel_c1;
      p2 <= in.pixel_c2;
    end
  end

  // Memories
  logic          col_we, use_we;
  logic [AW-1:0] col_waddr, col_raddr, use_waddr, use_raddr;
  logic [3*COL_W-1:0] col_wdata, col_rdata;
  logic [USE_W-1:0] use_wdata, use_rdata;

  ncbp_ram #(.WIDTH(3*COL_W), .DEPTH(MAX_ENTRIES)) u_col (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata));
  ncbp_ram #(.WIDTH(USE_W), .DEPTH(MAX_ENTRIES)) u_use (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .raddr(use_raddr), .rdata(use_rdata));

  // Scan counters
  logic [NW-1:0] rd_cnt;
  logic [AW-1:0] rd_idx_d;
  logic          rd_vld_d;
  logic [CW-1:0] pk;
  logic          pk_vld;
  logic [AW-1:0] pk_idx_d;
  logic [AW-1:0] best_idx;
  logic [USE_W-1:0] best_use;
  logic          best_set;

  logic [AW-1:0] sl_ridx;
  logic [CW-1:0] sl_cnt;
  logic          sl_clear;

  ncbp_shortlist #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_SHORTLIST(MAX_SHORTLIST)) u_sl (
    .clk(clk), .rst(rst), .clear(sl_clear), .ins(rd_vld_d),
    .cand_dist(sq_dist(col_rdata, p0, p1, p2)), .idx(rd_idx_d), .k(k_eff),
    .rsel(pk), .ridx(sl_ridx), .cnt(sl_cnt));

  logic load_ok;
  assign load_ok = (32'(q_idx) < MAX_ENTRIES);

  // Next state and memory controls
  always_comb begin
    state_next = state;
    col_we = 1'b0;
    col_waddr = AW'(q_idx);
    col_wdata = q_col;
    col_raddr = rd_cnt[AW-1:0];
    use_we = 1'b0;
    use_waddr = AW'(q_idx);
    use_wdata = '0;
    use_raddr = sl_ridx;
    sl_clear = 1'b0;
    case (state)
      S_IDLE: begin
        sl_clear = 1'b1;
        if (in.valid && in.ready) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (q_mode == MODE_LOAD) begin
          col_we = load_ok;
          use_we = load_ok;
          state_next = S_OUT;
        end else if (n_eff == '0) begin
          state_next = S_OUT;
        end else if (rd_cnt == n_eff - NW'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_PICK;
      S_PICK: state_next = S_PICKW;
      S_PICKW: begin
        if (pk == sl_cnt - CW'(1)) state_next = S_UPD;
        else state_next = S_PICK;
      end
      S_UPD: begin
        use_we = 1'b1;
        use_waddr = best_idx;
        use_wdata = (best_use == USE_MAX) ? best_use : best_use + USE_W'(1);
        state_next = S_OUT;
      end
      S_OUT: if (out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Scan pipeline and least-use pick
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      rd_vld_d <= 1'b0;
      pk <= '0;
      pk_vld <= 1'b0;
      best_set <= 1'b0;
    end else begin
      rd_vld_d <= (state == S_SCAN) && (q_mode == MODE_QUERY) && (n_eff != '0);
      rd_idx_d <= rd_cnt[AW-1:0];
      pk_vld <= (state == S_PICK);
      pk_idx_d <= sl_ridx;
      if (state == S_IDLE) begin
        rd_cnt <= '0;
        pk <= '0;
        best_set <= 1'b0;
      end else if (state == S_SCAN) begin
        rd_cnt <= rd_cnt + NW'(1);
      end else if (state == S_PICKW) begin
        pk <= pk + CW'(1);
      end
      if (pk_vld) begin
        if (!best_set || use_rdata < best_use ||
            (use_rdata == best_use && pk_idx_d < best_idx)) begin
          best_use <= use_rdata;
          best_idx <= pk_idx_d;
        end
        best_set <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == S_SCAN && (q_mode == MODE_LOAD || n_eff == '0)) begin
      out.chosen_index <= '0;
      out.chosen_uses  <= '0;
      out.status <= (q_mode == MODE_LOAD) ? ST_LOAD : ST_EMPTY;
    end else if (state == S_UPD) begin
      out.chosen_index <= IDX_W'(best_idx);
      out.chosen_uses  <= (best_use == USE_MAX) ? best_use : best_use + USE_W'(1);
      out.status <= ST_MATCH;
    end
  end

  assign out.valid = (state == S_OUT);
  assign in.ready  = (state == S_IDLE);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out.valid && in.ready))
    else $error("input taken while result pending");
  a_upd_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> best_set)
    else $error("update with no pick");
  a_col_we: assert property (@(posedge clk) disable iff (rst)
    col_we |-> (state == S_SCAN))
    else $error("color write outside load");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> out.valid && $stable(out.chosen_index) &&
      $stable(out.status) && $stable(out.chosen_uses))
    else $error("result changed while waiting");
endmodule

@@ tb/nearest_color_balanced_pick_top_tb.sv @@
module nearest_color_balanced_pick_top_tb;
  import ncbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    mode_t            mode;
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] m0, m1, m2;
    logic [PIX_W-1:0] p0, p1, p2;
  } pix_req_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    status_t          st;
    logic [USE_W-1:0] uses;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ncbp_in_if  in_ch();
  ncbp_out_if out_ch();

  nearest_color_balanced_pick_top dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow of the palette and the registers
  logic [COL_W-1:0] pal_col [MAX_ENTRIES_DEF][3];
  logic [USE_W-1:0] pal_uses [MAX_ENTRIES_DEF];
  bit               pal_written [MAX_ENTRIES_DEF];
  int unsigned      psize_reg = 0;
  int unsigned      ksize_reg = SHORTLIST_RESET;

  pix_req_t pending_reqs[$];
  pick_t    expected_picks[$];
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       fails = 0;

  // Nearest-K search followed by least-used pick, updating the shadow state
  function automatic pick_t predict_pick(pix_req_t r);
    pick_t       res;
    longint      sd [32];
    int unsigned si [32];
    int unsigned cnt, n, k, pos, best;
    longint      d, a;
    logic [COL_W-1:0] q [3];
    res.index = '0;
    res.uses = '0;
    if (r.mode == MODE_LOAD) begin
      pal_col[r.idx][0] = r.m0;
      pal_col[r.idx][1] = r.m1;
      pal_col[r.idx][2] = r.m2;
      pal_uses[r.idx] = '0;
      pal_written[r.idx] = 1'b1;
      res.st = ST_LOAD;
      return res;
    end
    n = (psize_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : psize_reg;
    if (n == 0) begin
      res.st = ST_EMPTY;
      return res;
    end
    k = (ksize_reg < 1) ? 1 : (ksize_reg > MAX_SHORTLIST_DEF) ? MAX_SHORTLIST_DEF : ksize_reg;
    q[0] = {r.p0, 4'h0};
    q[1] = {r.p1, 4'h0};
    q[2] = {r.p2, 4'h0};
    cnt = 0;
    for (int unsigned e = 0; e < n; e++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        a = longint'(pal_col[e][c]) - longint'(q[c]);
        d += a * a;
      end
      if (cnt == k && d >= sd[k-1]) continue;
      pos = (cnt < k) ? cnt : k - 1;
      while (pos > 0 && sd[pos-1] > d) begin
        sd[pos] = sd[pos-1];
        si[pos] = si[pos-1];
        pos--;
      end
      sd[pos] = d;
      si[pos] = e;
      if (cnt < k) cnt++;
    end
    best = si[0];
    for (int unsigned j = 1; j < cnt; j++)
      if (pal_uses[si[j]] < pal_uses[best] ||
          (pal_uses[si[j]] == pal_uses[best] && si[j] < best))
        best = si[j];
    if (pal_uses[best] != USE_MAX) pal_uses[best]++;
    res.index = best[IDX_W-1:0];
    res.st = ST_MATCH;
    res.uses = pal_uses[best];
    return res;
  endfunction

  function automatic void add_item(pix_req_t r);
    pending_reqs = {pending_reqs, r};
    expected_picks = {expected_picks, predict_pick(r)};
  endfunction

  function automatic logic [COL_W-1:0] pick_color();
    // Grid-aligned colors make exact distance ties likely
    if ($urandom_range(3) == 0) return {8'($urandom_range(3) * 85), 4'h0};
    return COL_W'($urandom);
  endfunction

  function automatic void add_load(int unsigned idx, logic [COL_W-1:0] c0,
                                   logic [COL_W-1:0] c1, logic [COL_W-1:0] c2);
    pix_req_t r;
    r.mode = MODE_LOAD;
    r.idx = idx[IDX_W-1:0];
    r.m0 = c0; r.m1 = c1; r.m2 = c2;
    r.p0 = PIX_W'($urandom); r.p1 = PIX_W'($urandom); r.p2 = PIX_W'($urandom);
    add_item(r);
  endfunction

  function automatic void add_query(logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                                    logic [PIX_W-1:0] p2);
    pix_req_t r;
    r.mode = MODE_QUERY;
    r.idx = IDX_W'($urandom);
    r.m0 = COL_W'($urandom); r.m1 = COL_W'($urandom); r.m2 = COL_W'($urandom);
    r.p0 = p0; r.p1 = p1; r.p2 = p2;
    add_item(r);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 8'($urandom_range(3) * 85);
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Load every not yet written entry that the next queries will cover
  function automatic void fill_palette(int unsigned n);
    for (int unsigned e = 0; e < n && e < MAX_ENTRIES_DEF; e++)
      if (!pal_written[e]) add_load(e, pick_color(), pick_color(), pick_color());
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_picks.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t ri, int unsigned val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {ri, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (ri == REG_PSIZE) psize_reg = val & 32'h7FF;
    else ksize_reg = val & 32'h3F;
  endtask

  task automatic set_regs(int unsigned ps, int unsigned ks);
    wait_idle();
    reg_write(REG_PSIZE, ps);
    reg_write(REG_KSIZE, ks);
  endtask

  // Driver: advance to the next pending item once the current one transfers
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_req_t r;
        r = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.mode <= r.mode;
        in_ch.entry_index <= r.idx;
        in_ch.mean_c0 <= r.m0; in_ch.mean_c1 <= r.m1; in_ch.mean_c2 <= r.m2;
        in_ch.pixel_c0 <= r.p0; in_ch.pixel_c1 <= r.p1; in_ch.pixel_c2 <= r.p2;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.entry_index = '0;
    in_ch.mean_c0 = '0; in_ch.mean_c1 = '0; in_ch.mean_c2 = '0;
    in_ch.pixel_c0 = '0; in_ch.pixel_c1 = '0; in_ch.pixel_c2 = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_picks.size() == 0) begin
        fails++;
        $display("%0t: unexpected result index=%0d status=%0d uses=%0d", $time,
                 out_ch.chosen_index, out_ch.status, out_ch.chosen_uses);
      end else begin
        pick_t e;
        e = expected_picks.pop_front();
        if (out_ch.status !== e.st) begin
          fails++;
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_ch.status);
        end
        if (out_ch.chosen_index !== e.index) begin
          fails++;
          $display("%0t: chosen_index expected %0d actual %0d", $time, e.index,
                   out_ch.chosen_index);
        end
        if (out_ch.chosen_uses !== e.uses) begin
          fails++;
          $display("%0t: chosen_uses expected %0d actual %0d", $time, e.uses,
                   out_ch.chosen_uses);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned ps;
    for (int e = 0; e < MAX_ENTRIES_DEF; e++) begin
      pal_written[e] = 1'b0;
      pal_uses[e] = '0;
      pal_col[e][0] = '0; pal_col[e][1] = '0; pal_col[e][2] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty palette query, then extreme loads and a duplicate color for ties
    add_query(8'h00, 8'hFF, 8'h80);
    add_load(0, 12'h000, 12'h000, 12'h000);
    add_load(1023, 12'hFFF, 12'hFFF, 12'hFFF);
    add_load(1, 12'hFFF, 12'h000, 12'hFFF);
    add_load(2, 12'h000, 12'hFFF, 12'h000);
    add_load(3, 12'h000, 12'h000, 12'h000);

    // Shortlist zero acts as one: always the nearest, lower index on ties
    set_regs(4, 0);
    add_query(8'h00, 8'h00, 8'h00);
    add_query(8'h00, 8'h00, 8'h00);
    add_query(8'hFF, 8'hFF, 8'hFF);
    add_query(8'hFF, 8'h00, 8'hFF);

    // Oversized shortlist covers all four; balancing rotates through them
    set_regs(4, 63);
    for (int i = 0; i < 6; i++) add_query(8'h00, 8'h00, 8'h00);
    add_load(2, 12'h010, 12'h020, 12'h030);
    add_query(8'h01, 8'h02, 8'h03);

    // Single entry with a shortlist of one: its use count climbs
    set_regs(1, 1);
    add_load(0, 12'h123, 12'h456, 12'h789);
    for (int i = 0; i < 5; i++) add_query(pick_pixel(), pick_pixel(), pick_pixel());
    add_load(0, 12'h000, 12'h000, 12'h000);

    // Random phases over several settings and idling patterns
    for (int ph = 0; ph < 9; ph++) begin
      ps = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 48);
      set_regs(ps, $urandom_range(63));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      fill_palette(ps);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(9) < 7)
          add_query(pick_pixel(), pick_pixel(), pick_pixel());
        else if ($urandom_range(4) == 0)
          add_load($urandom_range(1023), pick_color(), pick_color(), pick_color());
        else
          add_load($urandom_range(ps - 1), pick_color(), pick_color(), pick_color());
      end
      // Hold off until every result is back, then send a short burst
      wait_idle();
      for (int i = 0; i < 4; i++) add_query(pick_pixel(), pick_pixel(), pick_pixel());
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

endmodule
